// ----- rtl/osptt_pkg.sv -----
// Shared types and codes for the one-shot and periodic timer table.
package osptt_pkg;

    localparam int TIME_BITS = 48;
    localparam int SLOT_W = 4;
    localparam int COUNT_W = 5;
    localparam int TIMER_SLOTS = 16;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ONESHOT = 2'd1,
        OP_PERIODIC = 2'd2,
        OP_CANCEL = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_SET = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_CANCEL = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_ZERO = 2'd1,
        ST_FULL = 2'd2,
        ST_INACTIVE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIRE,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture input item
        logic tick;        // advance time
        logic scan_clear;  // start a selection pass
        logic scan_step;   // examine one slot
        logic fire;        // fire the selected slot
        logic do_set;      // perform set or cancel
        logic out_load;    // load output register
        logic out_last;    // last flag for that result
        logic clear_fired; // forget fired marks
    } dp_cmd_t;

    // Status back to the controller.
    typedef struct packed {
        logic scan_done;   // pass covered all slots
        logic found;       // a candidate was found
    } dp_stat_t;

endpackage

// ----- rtl/osptt_ctrl.sv -----
// Controller state machine for the timer table.
module osptt_ctrl
    import osptt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     is_tick,
    input  logic     out_busy,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.clear_fired = 1'b1;
                    state_next = S_OUT;
                    if (is_tick)
                    begin
                        cmd.tick = 1'b1;
                        cmd.scan_clear = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_OUT:
            begin
                // Set or cancel: one result.
                if (!out_busy)
                begin
                    cmd.do_set = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = stat.found ? S_FIRE : S_IDLE;
                end
            end
            S_FIRE:
            begin
                // The fired result is presented when the next pass ends.
                if (!out_busy)
                begin
                    cmd.fire = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/osptt_dp.sv -----
// Datapath of the timer table: slot storage, time, scan and result register.
module osptt_dp
    import osptt_pkg::*;
#(
    parameter int DELAY_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [1:0]            opcode,
    input  logic [31:0]           target_actor,
    input  logic [DELAY_BITS-1:0] delay_ms,
    input  logic [31:0]           message_tag,
    input  logic [3:0]            cancel_slot,
    output logic                  is_tick,
    output logic                  out_busy,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            result_kind,
    output logic [1:0]            status,
    output logic [3:0]            timer_slot,
    output logic [31:0]           fire_actor,
    output logic [31:0]           fire_message,
    output logic [4:0]            active_count,
    output logic                  last
);

    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);

    logic [TIMER_SLOTS-1:0] valid_reg, valid_next;
    logic [TIMER_SLOTS-1:0] fired_reg, fired_next;
    logic [TIME_BITS-1:0]   expire_mem [TIMER_SLOTS];
    logic [DELAY_BITS-1:0]  period_mem [TIMER_SLOTS];
    logic [31:0]            target_mem [TIMER_SLOTS];
    logic [31:0]            message_mem [TIMER_SLOTS];
    logic [TIME_BITS-1:0]   now_reg;
    logic [CW-1:0]          count_reg, count_next;
    logic [1:0]             op_reg;
    logic [31:0]            actor_reg, msg_reg;
    logic [DELAY_BITS-1:0]  delay_reg;
    logic [3:0]             cslot_reg;
    logic [SW:0]            idx_reg;
    logic [SW-1:0]          best_reg;
    logic                   found_reg;
    logic [TIME_BITS-1:0]   best_exp_reg;
    logic                   ov_reg;
    logic                   hold_reg;
    logic                   show_fire;
    logic [1:0]             kind_reg, st_reg;
    logic [3:0]             slot_out_reg;
    logic [31:0]            act_out_reg, msg_out_reg;
    logic [4:0]             cnt_out_reg;
    logic                   last_reg;

    // Lowest free slot search and cancel check.
    logic [SW-1:0] free_idx;
    logic          free_ok;
    logic          cancel_ok;
    logic [SW-1:0] cidx;
    always_comb
    begin
        free_idx = '0;
        free_ok = 1'b0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SW'(i);
                free_ok = 1'b1;
            end
        end
        cidx = SW'(cslot_reg);
        cancel_ok = (32'(cslot_reg) < 32'(TIMER_SLOTS)) && valid_reg[cidx];
    end

    // Slot under examination in the scan.
    logic [SW-1:0]        scan_idx;
    logic                 cand;
    logic [TIME_BITS-1:0] scan_exp;
    assign scan_idx = idx_reg[SW-1:0];
    assign scan_exp = expire_mem[scan_idx];
    assign cand = valid_reg[scan_idx] && !fired_reg[scan_idx] && (scan_exp <= now_reg)
                  && (!found_reg || scan_exp < best_exp_reg);
    assign stat.scan_done = (32'(idx_reg) == TIMER_SLOTS - 1);
    assign stat.found = found_reg || cand;
    assign is_tick = (opcode == OP_TICK);

    // A held firing is presented at the end of the pass that follows it.
    assign show_fire = cmd.scan_step && stat.scan_done && hold_reg;

    // Control side of the slot table.
    always_comb
    begin
        valid_next = valid_reg;
        fired_next = cmd.clear_fired ? '0 : fired_reg;
        count_next = count_reg;
        if (cmd.fire)
        begin
            fired_next[best_reg] = 1'b1;
            if (period_mem[best_reg] == '0)
            begin
                valid_next[best_reg] = 1'b0;
                count_next = count_reg - 1'b1;
            end
        end
        if (cmd.do_set)
        begin
            if (op_reg == OP_CANCEL)
            begin
                if (cancel_ok)
                begin
                    valid_next[cidx] = 1'b0;
                    count_next = count_reg - 1'b1;
                end
            end
            else if (!(op_reg == OP_PERIODIC && delay_reg == '0) && free_ok)
            begin
                valid_next[free_idx] = 1'b1;
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fired_reg <= '0;
            count_reg <= '0;
            now_reg <= '0;
            ov_reg <= 1'b0;
            hold_reg <= 1'b0;
            idx_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            fired_reg <= fired_next;
            count_reg <= count_next;
            if (cmd.tick)
            begin
                now_reg <= now_reg + 1'b1;
            end
            if (cmd.out_load || show_fire)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (cmd.fire)
            begin
                hold_reg <= 1'b1;
            end
            else if (show_fire)
            begin
                hold_reg <= 1'b0;
            end
            if (cmd.scan_clear)
            begin
                idx_reg <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= stat.scan_done ? '0 : idx_reg + 1'b1;
                if (cand)
                begin
                    found_reg <= 1'b1;
                end
                if (stat.scan_done)
                begin
                    found_reg <= stat.found;
                end
            end
        end
    end

    // Payload registers and slot storage.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode;
            actor_reg <= target_actor;
            msg_reg <= message_tag;
            delay_reg <= delay_ms;
            cslot_reg <= cancel_slot;
        end
        if (cmd.scan_step && cand)
        begin
            best_reg <= scan_idx;
            best_exp_reg <= scan_exp;
        end
        if (cmd.fire)
        begin
            expire_mem[best_reg] <= now_reg + TIME_BITS'(period_mem[best_reg]);
            kind_reg <= KIND_FIRED;
            st_reg <= ST_OK;
            slot_out_reg <= 4'(best_reg);
            act_out_reg <= target_mem[best_reg];
            msg_out_reg <= message_mem[best_reg];
            cnt_out_reg <= 5'(count_next);
            last_reg <= 1'b0;
        end
        if (cmd.do_set)
        begin
            act_out_reg <= '0;
            msg_out_reg <= '0;
            cnt_out_reg <= 5'(count_next);
            last_reg <= 1'b1;
            if (op_reg == OP_CANCEL)
            begin
                kind_reg <= KIND_CANCEL;
                st_reg <= cancel_ok ? ST_OK : ST_INACTIVE;
                slot_out_reg <= cslot_reg;
            end
            else
            begin
                kind_reg <= KIND_SET;
                slot_out_reg <= '0;
                if (op_reg == OP_PERIODIC && delay_reg == '0)
                begin
                    st_reg <= ST_ZERO;
                end
                else if (!free_ok)
                begin
                    st_reg <= ST_FULL;
                end
                else
                begin
                    st_reg <= ST_OK;
                    slot_out_reg <= 4'(free_idx);
                    expire_mem[free_idx] <= now_reg + TIME_BITS'(delay_reg);
                    period_mem[free_idx] <= (op_reg == OP_PERIODIC) ? delay_reg : '0;
                    target_mem[free_idx] <= actor_reg;
                    message_mem[free_idx] <= msg_reg;
                end
            end
        end
        // A held firing is the last one when the pass after it finds nothing.
        if (show_fire)
        begin
            last_reg <= !stat.found;
        end
    end

    assign out_busy = ov_reg && !out_ready;
    assign out_valid = ov_reg;
    assign result_kind = kind_reg;
    assign status = st_reg;
    assign timer_slot = slot_out_reg;
    assign fire_actor = act_out_reg;
    assign fire_message = msg_out_reg;
    assign active_count = cnt_out_reg;
    assign last = last_reg;

endmodule

// ----- rtl/one_shot_and_periodic_timer_table.sv -----
// Top level of the one-shot and periodic timer table.
// Set and cancel: the result is registered from S_OUT once the output is not busy;
// the next input is taken back in S_IDLE. Tick: one serial slot scan, plus one
// S_FIRE step and one more scan per firing; S_FIRE also waits on a busy output.
// Each firing is presented when the scan after it ends, which decides its last flag.
// Reset clears time and all slot valid bits; slot contents are written on use.
module one_shot_and_periodic_timer_table
    import osptt_pkg::*;
#(
    parameter int DELAY_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            opcode,
    input  logic [31:0]           target_actor,
    input  logic [DELAY_BITS-1:0] delay_ms,
    input  logic [31:0]           message_tag,
    input  logic [3:0]            cancel_slot,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            result_kind,
    output logic [1:0]            status,
    output logic [3:0]            timer_slot,
    output logic [31:0]           fire_actor,
    output logic [31:0]           fire_message,
    output logic [4:0]            active_count,
    output logic                  last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     is_tick;
    logic     out_busy;
    logic     ov_int;

    osptt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .is_tick  (is_tick),
        .out_busy (out_busy),
        .stat     (stat),
        .cmd      (cmd)
    );

    osptt_dp #(
        .DELAY_BITS  (DELAY_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .target_actor (target_actor),
        .delay_ms     (delay_ms),
        .message_tag  (message_tag),
        .cancel_slot  (cancel_slot),
        .is_tick      (is_tick),
        .out_busy     (out_busy),
        .out_valid    (ov_int),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .status       (status),
        .timer_slot   (timer_slot),
        .fire_actor   (fire_actor),
        .fire_message (fire_message),
        .active_count (active_count),
        .last         (last)
    );

    // The datapath raises the result only once its last flag is known.
    assign out_valid = ov_int;

    // A fired result never reports a status other than ok.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == KIND_FIRED) |-> (status == ST_OK))
        else $error("fired result with bad status");

    // Active count never exceeds the slot count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(active_count) <= TIMER_SLOTS))
        else $error("active count out of range");

    // No new input while a result is pending, unless it is being taken or is the last of its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready || out_ready || last)
        else $error("input accepted mid-item");

endmodule

// ----- tb/timer_table_checker.sv -----
// Checker that predicts and compares the timer table's results.
module timer_table_checker
    import osptt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [31:0] target_actor,
    input  logic [23:0] delay_ms,
    input  logic [31:0] message_tag,
    input  logic [3:0]  cancel_slot,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  result_kind,
    input  logic [1:0]  status,
    input  logic [3:0]  timer_slot,
    input  logic [31:0] fire_actor,
    input  logic [31:0] fire_message,
    input  logic [4:0]  active_count,
    input  logic        last,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        kind_t       kind;
        status_t     stat;
        logic [3:0]  slot;
        logic [31:0] actor;
        logic [31:0] msg;
        logic [4:0]  count;
        logic        fin;
    } timer_result_t;

    // Predicted copy of the timer table.
    logic [47:0] now_time;
    logic        armed [16];
    logic [47:0] expiry [16];
    logic [23:0] period [16];
    logic [31:0] actor_of [16];
    logic [31:0] msg_of [16];
    timer_result_t expected_results[$];

    assign pending_count = expected_results.size();

    function automatic logic [4:0] armed_total();
        logic [4:0] c;
        c = '0;
        for (int i = 0; i < 16; i++)
            c = c + 5'(armed[i]);
        return c;
    endfunction

    task automatic push_result(kind_t k, status_t s, logic [3:0] sl, logic [31:0] a,
                               logic [31:0] m);
        timer_result_t r;
        r.kind = k;
        r.stat = s;
        r.slot = sl;
        r.actor = a;
        r.msg = m;
        r.count = armed_total();
        r.fin = 1'b0;
        expected_results.push_back(r);
    endtask

    // Work out the results of one accepted command.
    task automatic apply_command(opcode_t op, logic [31:0] a, logic [23:0] d,
                                 logic [31:0] m, logic [3:0] cs);
        int n0;
        int best;
        int free_slot;
        logic done [16];
        n0 = expected_results.size();
        case (op)
            OP_TICK:
            begin
                for (int i = 0; i < 16; i++)
                    done[i] = 1'b0;
                now_time = now_time + 48'd1;
                forever
                begin
                    best = -1;
                    for (int i = 0; i < 16; i++)
                        if (armed[i] && !done[i] && expiry[i] <= now_time)
                            if (best < 0 || expiry[i] < expiry[best])
                                best = i;
                    if (best < 0)
                        break;
                    done[best] = 1'b1;
                    if (period[best] != 0)
                        expiry[best] = now_time + 48'(period[best]);
                    else
                        armed[best] = 1'b0;
                    push_result(KIND_FIRED, ST_OK, 4'(best), actor_of[best],
                                msg_of[best]);
                end
            end
            OP_ONESHOT, OP_PERIODIC:
            begin
                free_slot = -1;
                for (int i = 15; i >= 0; i--)
                    if (!armed[i])
                        free_slot = i;
                if (op == OP_PERIODIC && d == 0)
                    push_result(KIND_SET, ST_ZERO, 4'd0, 32'd0, 32'd0);
                else if (free_slot < 0)
                    push_result(KIND_SET, ST_FULL, 4'd0, 32'd0, 32'd0);
                else
                begin
                    armed[free_slot] = 1'b1;
                    expiry[free_slot] = now_time + 48'(d);
                    period[free_slot] = (op == OP_PERIODIC) ? d : 24'd0;
                    actor_of[free_slot] = a;
                    msg_of[free_slot] = m;
                    push_result(KIND_SET, ST_OK, 4'(free_slot), 32'd0, 32'd0);
                end
            end
            default:
            begin
                if (armed[cs])
                begin
                    armed[cs] = 1'b0;
                    push_result(KIND_CANCEL, ST_OK, cs, 32'd0, 32'd0);
                end
                else
                    push_result(KIND_CANCEL, ST_INACTIVE, cs, 32'd0, 32'd0);
            end
        endcase
        if (expected_results.size() > n0)
            expected_results[expected_results.size() - 1].fin = 1'b1;
    endtask

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // Watch both channels at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t e;
        if (!rst_n)
        begin
            now_time = '0;
            fail_count = 0;
            for (int i = 0; i < 16; i++)
                armed[i] = 1'b0;
            expected_results.delete();
        end
        else
        begin
            // Compare the output transfer first: the result of an item
            // cannot appear in the same cycle that the item is taken.
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 48'(result_kind), 48'd0);
                else
                begin
                    e = expected_results.pop_front();
                    if (result_kind != e.kind)
                        report_mismatch("result_kind", 48'(result_kind), 48'(e.kind));
                    if (status != e.stat)
                        report_mismatch("status", 48'(status), 48'(e.stat));
                    if (timer_slot != e.slot)
                        report_mismatch("timer_slot", 48'(timer_slot), 48'(e.slot));
                    if (fire_actor != e.actor)
                        report_mismatch("fire_actor", 48'(fire_actor), 48'(e.actor));
                    if (fire_message != e.msg)
                        report_mismatch("fire_message", 48'(fire_message), 48'(e.msg));
                    if (active_count != e.count)
                        report_mismatch("active_count", 48'(active_count), 48'(e.count));
                    if (last != e.fin)
                        report_mismatch("last", 48'(last), 48'(e.fin));
                end
            end
            if (in_valid && in_ready)
                apply_command(opcode_t'(opcode), target_actor, delay_ms, message_tag,
                              cancel_slot);
        end
    end

endmodule

// ----- tb/one_shot_and_periodic_timer_table_tb.sv -----
// Testbench top for the timer table: stimulus, flow control and verdict.
module one_shot_and_periodic_timer_table_tb;
    import osptt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [31:0] target_actor;
    logic [23:0] delay_ms;
    logic [31:0] message_tag;
    logic [3:0]  cancel_slot;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_kind;
    logic [1:0]  status;
    logic [3:0]  timer_slot;
    logic [31:0] fire_actor;
    logic [31:0] fire_message;
    logic [4:0]  active_count;
    logic        last;
    int          fail_count;
    int          pending_count;
    int          cycle_count;
    bit          hold_off;

    localparam int CYCLE_LIMIT = 900000;

    one_shot_and_periodic_timer_table u_dut (.*);

    timer_table_checker u_checker (.*);

    // Clock generation.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle counter with a generous timeout.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver stall pattern, with one long hold-off when requested.
    initial out_ready = 1'b0;
    always @(posedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else if (cycle_count[9:8] == 2'd1)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        hold_off = 1'b0;
        wait (cycle_count == 3000);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    // Offer one command and wait for its transfer; ready is looked at
    // between edges so that the accepting edge is the one that follows.
    task automatic send_command(opcode_t op, logic [31:0] a, logic [23:0] d,
                                logic [31:0] m, logic [3:0] cs);
        in_valid <= 1'b1;
        opcode <= op;
        target_actor <= a;
        delay_ms <= d;
        message_tag <= m;
        cancel_slot <= cs;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random command, mostly sets with short delays and ticks.
    task automatic random_command();
        int pick;
        logic [23:0] d;
        pick = $urandom_range(0, 99);
        d = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6));
        if (pick < 45)
            send_command(OP_TICK, $urandom, 24'($urandom), $urandom, 4'($urandom));
        else if (pick < 65)
            send_command(OP_ONESHOT, $urandom, d, $urandom, 4'($urandom));
        else if (pick < 85)
            send_command(OP_PERIODIC, $urandom, d, $urandom, 4'($urandom));
        else
            send_command(OP_CANCEL, $urandom, 24'($urandom), $urandom, 4'($urandom));
    endtask

    initial
    begin
        in_valid = 1'b0;
        opcode = OP_TICK;
        target_actor = '0;
        delay_ms = '0;
        message_tag = '0;
        cancel_slot = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty tick, cancel of free slot, zero period, zero delay.
        send_command(OP_TICK, 32'd0, 24'd0, 32'd0, 4'd0);
        send_command(OP_CANCEL, 32'd0, 24'd0, 32'd0, 4'd15);
        send_command(OP_PERIODIC, '1, 24'd0, '1, 4'd0);
        send_command(OP_ONESHOT, '1, 24'd0, '1, '1);
        send_command(OP_PERIODIC, 32'h5555_aaaa, 24'd1, 32'haaaa_5555, 4'd0);
        send_command(OP_ONESHOT, 32'd0, 24'hffffff, 32'd0, 4'd0);
        send_command(OP_TICK, 32'd0, 24'd0, 32'd0, 4'd0);
        send_command(OP_TICK, 32'd0, 24'd0, 32'd0, 4'd0);
        // Fill the table to overflow, then fire many at once.
        for (int i = 0; i < 16; i++)
            send_command(OP_ONESHOT, 32'(i), 24'd1, 32'(i * 7), 4'd0);
        send_command(OP_TICK, 32'd0, 24'd0, 32'd0, 4'd0);
        send_command(OP_CANCEL, 32'd0, 24'd0, 32'd0, 4'd0);
        send_command(OP_CANCEL, 32'd0, 24'd0, 32'd0, 4'd1);

        // Random part in bursts.
        for (int i = 0; i < 410; i++)
        begin
            random_command();
            idle_gap();
        end
        in_valid <= 1'b0;

        // Let the checker take in the final transfer before draining.
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- one_shot_and_periodic_timer_table.f -----
rtl/osptt_pkg.sv
rtl/osptt_ctrl.sv
rtl/osptt_dp.sv
rtl/one_shot_and_periodic_timer_table.sv
tb/timer_table_checker.sv
tb/one_shot_and_periodic_timer_table_tb.sv
